// ===== sv/mrl_pkg.sv =====
// package for the mountain removal block: sizes, controller states and the
// command and status words between controller and datapath. no dependencies.
package mrl_pkg;

    localparam int MAX_LEN    = 1024;
    localparam int VALUE_BITS = 32;
    localparam int IN_W       = 32;
    localparam int RESULT_W   = 11;
    localparam int ADDR_W     = $clog2(MAX_LEN);
    localparam int CNT_W      = $clog2(MAX_LEN + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FSRCH,
        ST_BINIT,
        ST_BREAD,
        ST_BLOAD,
        ST_BSRCH,
        ST_FINISH
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;     // take the input word, store it, start a search
        logic search;     // one lower-bound step over the tails store
        logic place_fwd;  // place key, keep rise length, count the element
        logic back_init;  // clear the tail count and best, start the backward walk
        logic back_load;  // take stored value and rise length, start a search
        logic place_bwd;  // place key, update best mountain, step back
        logic finish;     // load the result register and clear the counts
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic room;       // fewer than the maximum elements stored
        logic last;       // latched last flag of the current word
        logic done;       // search interval empty
        logic cnt_zero;   // no stored elements
        logic pos_one;    // backward walk at its final element
        logic out_free;   // result register can take a new word
    } t_stat;

endpackage

// ===== sv/mrl_ram.sv =====
// generic simple dual-port ram, one write and one registered read port.
// no dependencies.
module mrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/mrl_ctrl.sv =====
// controller state machine: sequences loading, backward walk and result.
// depends on mrl_pkg.
module mrl_ctrl import mrl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_last,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.room) begin
                        n_state = ST_FSRCH;
                    end else if (i_last) begin
                        n_state = ST_BINIT;
                    end
                end
            end
            ST_FSRCH: begin
                if (!i_stat.done) begin
                    o_cmd.search = 1'b1;
                end else begin
                    o_cmd.place_fwd = 1'b1;
                    n_state = i_stat.last ? ST_BINIT : ST_IDLE;
                end
            end
            ST_BINIT: begin
                o_cmd.back_init = 1'b1;
                n_state = i_stat.cnt_zero ? ST_FINISH : ST_BREAD;
            end
            ST_BREAD: begin
                n_state = ST_BLOAD;
            end
            ST_BLOAD: begin
                o_cmd.back_load = 1'b1;
                n_state = ST_BSRCH;
            end
            ST_BSRCH: begin
                if (!i_stat.done) begin
                    o_cmd.search = 1'b1;
                end else begin
                    o_cmd.place_bwd = 1'b1;
                    n_state = i_stat.pos_one ? ST_FINISH : ST_BREAD;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/mrl_dp.sv =====
// datapath: value, rise length and tails stores, lower-bound search,
// counters and the result register. depends on mrl_pkg and mrl_ram.
module mrl_dp import mrl_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [IN_W-1:0]     i_value,
    input  logic                i_last,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [RESULT_W-1:0] o_removals,
    output logic                o_found
);

    logic [VALUE_BITS-1:0] r_key,  n_key;
    logic                  r_last;
    logic [CNT_W-1:0]      r_item_count, n_item_count;
    logic [CNT_W-1:0]      r_tail_count, n_tail_count;
    logic [CNT_W-1:0]      r_lo, n_lo, r_hi, n_hi;
    logic [CNT_W-1:0]      r_best, n_best;
    logic [CNT_W-1:0]      r_pos, n_pos;
    logic [CNT_W-1:0]      r_rise;
    logic                  r_out_valid;
    logic [RESULT_W-1:0]   r_removals;
    logic                  r_found;

    logic [63:0]           in_ext;
    logic [VALUE_BITS-1:0] in_key;
    logic [CNT_W:0]        cur_sum, nxt_sum, mtn;
    logic [CNT_W-1:0]      cur_mid, pos_m1;
    logic                  lo_lt_hi, lo_in_range;
    logic [VALUE_BITS-1:0] tails_rdata, vs_rdata;
    logic [CNT_W-1:0]      rl_rdata;
    logic                  place;

    // offset-binary key: sign extend, keep the value width, flip the sign bit
    assign in_ext = {{(64 - IN_W){i_value[IN_W-1]}}, i_value};
    assign in_key = in_ext[VALUE_BITS-1:0] ^ {1'b1, {(VALUE_BITS - 1){1'b0}}};

    // search interval midpoint
    assign cur_sum     = {1'b0, r_lo} + {1'b0, r_hi};
    assign cur_mid     = cur_sum[CNT_W:1];
    assign lo_lt_hi    = r_lo < r_hi;
    assign lo_in_range = r_lo < CNT_W'(MAX_LEN);
    assign place       = i_cmd.place_fwd | i_cmd.place_bwd;
    assign pos_m1      = r_pos - CNT_W'(1);
    assign mtn         = {1'b0, r_rise} + {1'b0, r_lo};

    // next values of the search, count and walk registers
    always_comb begin
        n_key        = r_key;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_item_count = r_item_count;
        n_tail_count = r_tail_count;
        n_best       = r_best;
        n_pos        = r_pos;
        if (i_cmd.accept) begin
            n_key = in_key;
            n_lo  = '0;
            n_hi  = r_tail_count;
        end
        if (i_cmd.back_load) begin
            n_key = vs_rdata;
            n_lo  = '0;
            n_hi  = r_tail_count;
        end
        if (i_cmd.search && lo_lt_hi) begin
            if (tails_rdata < r_key) begin
                n_lo = cur_mid + CNT_W'(1);
            end else begin
                n_hi = cur_mid;
            end
        end
        if (place && lo_in_range && (r_lo == r_tail_count)) begin
            n_tail_count = r_tail_count + CNT_W'(1);
        end
        if (i_cmd.place_fwd) begin
            n_item_count = r_item_count + CNT_W'(1);
        end
        if (i_cmd.place_bwd) begin
            n_pos = pos_m1;
            if ((r_rise >= CNT_W'(2)) && (r_lo >= CNT_W'(1)) && (mtn > {1'b0, r_best})) begin
                n_best = mtn[CNT_W-1:0];
            end
        end
        if (i_cmd.back_init) begin
            n_tail_count = '0;
            n_best       = '0;
            n_pos        = r_item_count;
        end
        if (i_cmd.finish) begin
            n_item_count = '0;
            n_tail_count = '0;
            n_best       = '0;
        end
    end

    // the tails read address follows the next interval, so the read data lines up with the registered interval
    assign nxt_sum = {1'b0, n_lo} + {1'b0, n_hi};

    // counters and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count <= '0;
            r_tail_count <= '0;
            r_best       <= '0;
            r_pos        <= '0;
            r_lo         <= '0;
            r_hi         <= '0;
            r_last       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_item_count <= n_item_count;
            r_tail_count <= n_tail_count;
            r_best       <= n_best;
            r_pos        <= n_pos;
            r_lo         <= n_lo;
            r_hi         <= n_hi;
            if (i_cmd.accept) begin
                r_last <= i_last;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (i_cmd.back_load) begin
            r_rise <= rl_rdata;
        end
        if (i_cmd.finish) begin
            r_found    <= r_best != '0;
            r_removals <= (r_best != '0) ? RESULT_W'(r_item_count - r_best) : '0;
        end
    end

    // stored values, written as each element arrives while there is room
    mrl_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_LEN)) u_value_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept & (r_item_count < CNT_W'(MAX_LEN))),
        .i_waddr (r_item_count[ADDR_W-1:0]),
        .i_wdata (in_key),
        .i_raddr (pos_m1[ADDR_W-1:0]),
        .o_rdata (vs_rdata)
    );

    // increasing lengths per position
    mrl_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LEN)) u_rise_length (
        .i_clk   (i_clk),
        .i_we    (i_cmd.place_fwd),
        .i_waddr (r_item_count[ADDR_W-1:0]),
        .i_wdata (r_lo + CNT_W'(1)),
        .i_raddr (pos_m1[ADDR_W-1:0]),
        .o_rdata (rl_rdata)
    );

    // patience sorting tails
    mrl_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_LEN)) u_tails (
        .i_clk   (i_clk),
        .i_we    (place & lo_in_range),
        .i_waddr (r_lo[ADDR_W-1:0]),
        .i_wdata (r_key),
        .i_raddr (nxt_sum[ADDR_W:1]),
        .o_rdata (tails_rdata)
    );

    // status to the controller
    assign o_stat.room     = r_item_count < CNT_W'(MAX_LEN);
    assign o_stat.last     = r_last;
    assign o_stat.done     = !lo_lt_hi;
    assign o_stat.cnt_zero = r_item_count == '0;
    assign o_stat.pos_one  = r_pos == CNT_W'(1);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_removals  = r_removals;
    assign o_found     = r_found;

endmodule

// ===== sv/mountain_removal_lis_lds.sv =====
// fewest removals that leave a mountain, patience sorting in both directions.
// a stored word is taken in idle, then searched by lower bound on the tails ram
// read port and placed; a dropped word is only taken in idle. the last word
// adds a backward walk that reads, loads, searches and places each stored
// element; one result word, held in an output register. synchronous active-low
// reset clears the counters and control; ram contents are not cleared.
module mountain_removal_lis_lds import mrl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [10:0] removals, [15:11] zero
    output logic        m_axis_tuser    // [0] found
);

    t_cmd                cmd;
    t_stat               stat;
    logic [RESULT_W-1:0] removals;

    // sequencer
    mrl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_last  (s_axis_tlast),
        .o_ready (s_axis_tready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // stores, search and result
    mrl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_removals  (removals),
        .o_found     (m_axis_tuser)
    );

    assign m_axis_tdata = {{(16 - RESULT_W){1'b0}}, removals};

endmodule

// ===== bench/mountain_removal_lis_lds_tb.sv =====
// self-checking bench for the mountain removal block: sends signed sequences and
// checks each removals/found word against a patience-sort predictor.
// depends on mrl_pkg and mountain_removal_lis_lds.
module mountain_removal_lis_lds_tb import mrl_pkg::*; ();

    localparam int CLK_PERIOD     = 8;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int MAX_REPORTS    = 10;

    typedef logic signed [VALUE_BITS-1:0] t_value;

    localparam t_value VAL_MIN = {1'b1, {(VALUE_BITS - 1){1'b0}}};
    localparam t_value VAL_MAX = {1'b0, {(VALUE_BITS - 1){1'b1}}};

    // one expected output word
    typedef struct packed {
        logic [RESULT_W-1:0] removals;
        logic                found;
    } t_verdict;

    // shapes of random sequences
    typedef enum logic [2:0] {
        SHAPE_PEAK,
        SHAPE_NARROW,
        SHAPE_WIDE,
        SHAPE_MONO,
        SHAPE_FLAT
    } t_shape;

    // receiver stall modes
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_PATTERN,
        STALL_RANDOM,
        STALL_LONG
    } t_stall;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // [31:0] value
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [10:0] removals, [15:11] zero
    logic        m_axis_tuser;          // [0] found

    t_value   open_sequence[$];
    t_verdict removals_due[$];
    int       mismatch_count = 0;
    int       burst_left     = 0;

    t_stall      rx_mode    = STALL_NONE;
    logic [31:0] rx_pattern = '0;
    logic [15:0] rx_cycle   = '0;

    mountain_removal_lis_lds u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // fewest removals: forward pass gives rise lengths, backward pass the fall
    // lengths, both by lower bound over a pile of tails
    function automatic t_verdict predict_removals(input t_value vals[$]);
        t_value   piles[$];
        int       rise[MAX_LEN];
        int       n, k, idx, lo, hi, mid, best;
        t_verdict verdict;
        n    = vals.size();
        best = 0;
        for (k = 0; k < 2 * n; k++) begin
            if (k == n)
                piles.delete();
            idx = (k < n) ? k : 2 * n - 1 - k;
            lo  = 0;
            hi  = piles.size();
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (piles[mid] < vals[idx])
                    lo = mid + 1;
                else
                    hi = mid;
            end
            if (lo == piles.size())
                piles.insert(piles.size(), vals[idx]);
            else
                piles[lo] = vals[idx];
            // mountain length is rise + fall - 1, fall being lo + 1
            if (k < n)
                rise[idx] = lo + 1;
            else if (rise[idx] >= 2 && lo >= 1 && rise[idx] + lo > best)
                best = rise[idx] + lo;
        end
        verdict.found    = (best > 0);
        verdict.removals = verdict.found ? RESULT_W'(n - best) : '0;
        return verdict;
    endfunction

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // send one word in bursts with random gaps, then update the predictor
    task automatic send_word(input t_value value, input bit is_last);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= is_last;
        do @(posedge i_clk); while (!s_axis_tready);
        // elements beyond the store depth are dropped
        if (open_sequence.size() < MAX_LEN)
            open_sequence.insert(open_sequence.size(), value);
        if (is_last) begin
            removals_due.insert(removals_due.size(), predict_removals(open_sequence));
            open_sequence.delete();
        end
    endtask

    task automatic send_sequence(input t_value vals[$]);
        int k;
        for (k = 0; k < vals.size(); k++)
            send_word(vals[k], k == vals.size() - 1);
    endtask

    // hold the sender off until every expected word has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (removals_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_single_element();
        t_value q[$];
        q = '{32'sd0};
        send_sequence(q);
    endtask

    task automatic test_value_extremes();
        t_value q[$];
        q = '{VAL_MIN, VAL_MAX, VAL_MIN};
        send_sequence(q);
        // valley between extremes, no peak
        q = '{VAL_MAX, VAL_MIN, VAL_MAX};
        send_sequence(q);
    endtask

    task automatic test_no_peak();
        t_value q[$];
        q = '{32'sd1, 32'sd2, 32'sd3};
        send_sequence(q);
        q = '{32'sd3, 32'sd2, 32'sd1};
        send_sequence(q);
        // equal values never count as rising or falling
        q = '{32'sd5, 32'sd5, 32'sd5};
        send_sequence(q);
    endtask

    task automatic test_mixed_peaks();
        t_value q[$];
        q = '{32'sd2, 32'sd1, 32'sd1, 32'sd5, 32'sd6, 32'sd2, 32'sd3, 32'sd1};
        send_sequence(q);
    endtask

    // fill the store, then drop a few words, the last of them ending the run
    task automatic test_store_overflow();
        t_value q[$];
        int     k;
        for (k = 0; k < MAX_LEN + 3; k++) begin
            if (k >= MAX_LEN)
                q.insert(q.size(), $urandom);
            else if (k < 700)
                q.insert(q.size(), 2 * k + int'($urandom_range(0, 3)));
            else
                q.insert(q.size(), 4 * (MAX_LEN - k) + int'($urandom_range(0, 3)));
        end
        send_sequence(q);
        drain_results();
    endtask

    // mostly short mountain-like runs, with noise and peakless runs mixed in
    task automatic test_random_sequences(input int target);
        t_value q[$];
        t_value cur;
        t_shape shape;
        int     sent, len, k, pk, pick, step;
        bit     upward;
        sent = 0;
        while (sent < target) begin
            len  = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 160)
                                                : $urandom_range(1, 24);
            pick = $urandom_range(0, 9);
            shape = (pick < 5) ? SHAPE_PEAK : (pick < 7) ? SHAPE_NARROW :
                    (pick == 7) ? SHAPE_WIDE : (pick == 8) ? SHAPE_MONO : SHAPE_FLAT;
            pk     = $urandom_range(0, len - 1);
            upward = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 2))
                0: cur = int'($urandom_range(0, 2000)) - 1000;
                1: cur = VAL_MAX - t_value'(8 * len);
                default: cur = VAL_MIN + t_value'(8 * len);
            endcase
            if (shape == SHAPE_FLAT)
                cur = $urandom;
            q.delete();
            for (k = 0; k < len; k++) begin
                case (shape)
                    SHAPE_PEAK: begin
                        q.insert(q.size(), cur);
                        step = int'($urandom_range(0, 4)) - 1;
                        cur  = (k < pk) ? cur + step : cur - step;
                    end
                    SHAPE_NARROW: q.insert(q.size(), int'($urandom_range(0, 10)) - 5);
                    SHAPE_WIDE:   q.insert(q.size(), $urandom);
                    SHAPE_MONO: begin
                        q.insert(q.size(), cur);
                        step = $urandom_range(0, 3);
                        cur  = upward ? cur + step : cur - step;
                    end
                    default: q.insert(q.size(), cur);
                endcase
            end
            send_sequence(q);
            sent += len;
            if ($urandom_range(0, 11) == 0)
                drain_results();
        end
    endtask

    // receiver readiness: mode and pattern change whenever rx_cycle[6:0] is zero
    always @(posedge i_clk) begin : drive_ready
        logic rdy;
        rx_cycle <= rx_cycle + 1'b1;
        if (rx_cycle[6:0] == '0) begin
            rx_mode    <= t_stall'($urandom_range(0, 3));
            rx_pattern <= $urandom;
        end
        case (rx_mode)
            STALL_NONE:    rdy = 1'b1;
            STALL_PATTERN: rdy = rx_pattern[rx_cycle[4:0]];
            STALL_RANDOM:  rdy = ($urandom_range(0, 3) != 0);
            default:       rdy = (rx_cycle[3:0] >= 4'd10);
        endcase
        m_axis_tready <= rdy;
    end

    // compare each output word with the oldest expected one
    always @(posedge i_clk) begin : check_results
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (removals_due.size() == 0) begin
                flag_error($sformatf("unexpected word removals=%0d found=%0b",
                                     m_axis_tdata[RESULT_W-1:0], m_axis_tuser));
            end else begin
                want = removals_due.pop_front();
                if (m_axis_tdata !== 16'(want.removals) || m_axis_tuser !== want.found)
                    flag_error($sformatf("expected removals=%0d found=%0b, got tdata=%h found=%b",
                                         want.removals, want.found,
                                         m_axis_tdata, m_axis_tuser));
            end
        end
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_element();
        test_value_extremes();
        test_no_peak();
        test_mixed_peaks();
        test_store_overflow();
        test_random_sequences(800);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && removals_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
